/* rtl/ublr_pkg.sv */
// ----------------------------------------------------------------------------
// ublr_pkg: shared constants and types for the bounded LCG random block
// Holds widths, generator constants, mode codes and the front/back word type.
// ----------------------------------------------------------------------------
package ublr_pkg;

   localparam int CAND_BITS  = 31;
   localparam int STATE_BITS = 48;
   localparam int RANGE_BITS = 32;
   localparam int RNG_BITS   = CAND_BITS + 1;

   localparam logic [STATE_BITS-1:0] LCG_MULT   = 48'h0005DEECE66D;
   localparam logic [STATE_BITS-1:0] LCG_INC    = 48'h00000000000B;
   localparam logic [STATE_BITS-1:0] SEED_RESET = 48'd20017429951246;

   localparam logic [1:0] MODE_LCG  = 2'd0;
   localparam logic [1:0] MODE_MIN  = 2'd1;
   localparam logic [1:0] MODE_HALF = 2'd2;
   localparam logic [1:0] MODE_MAX  = 2'd3;

   localparam logic [0:0] CSR_MODE = 1'd0;
   localparam logic [0:0] CSR_SEED = 1'd1;

   // classified request: fixed answer or a draw with a saturated range
   typedef struct packed {
      logic                 draw;
      logic [RNG_BITS-1:0]  range;
      logic [CAND_BITS-1:0] fixed;
   } job_type;

endpackage

/* rtl/unbiased_bounded_lcg_random.sv */
// ----------------------------------------------------------------------------
// unbiased_bounded_lcg_random: bounded uniform values from a 48-bit LCG
// Usage: a request word on req_ carries the exclusive bound (1..2^31,
// larger bounds saturate). One value word per request leaves on rsp_, in
// request order. csr_ writes register 0 (mode) or 1 (seed, loads the
// generator state); write only while idle.
// Sequence: fixed modes go straight to the result register. Generator
// mode: the rejection limit (2^31 mod range, bit-serial), then LCG tries
// (three 16-bit partial products plus check each) until one passes, then
// the final bit-serial modulo; one item at a time in the back end.
// A two-word queue lets requests enter while the engine works; the result
// register holds a stalled word and the engine waits on it.
// Reset: mode 0, state = seed reset value, queue and result empty.
// ----------------------------------------------------------------------------
module unbiased_bounded_lcg_random
   import ublr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [RANGE_BITS-1:0]  req_tdata,   // [31:0] range
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [30:0] value
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [STATE_BITS-1:0]  csr_wdata
);

   logic [1:0]           mode_ff;
   logic                 job_valid, job_ready;
   job_type              job;
   logic [CAND_BITS-1:0] value;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LCG;
      end else if (csr_we && csr_index == CSR_MODE) begin
         mode_ff <= csr_wdata[1:0];
      end
   end

   ublr_front u_front (
      .clock, .reset, .mode(mode_ff), .req_tvalid, .req_tready, .req_tdata,
      .job_valid, .job_ready, .job
   );

   ublr_back u_back (
      .clock, .reset, .seed_we(csr_we && csr_index == CSR_SEED), .seed(csr_wdata),
      .job_valid, .job_ready, .job, .rsp_tvalid, .rsp_tready, .rsp_value(value)
   );

   assign rsp_tdata = {1'b0, value};

endmodule

/* rtl/ublr_front.sv */
// ----------------------------------------------------------------------------
// ublr_front: request intake and classification
// Saturates the range, resolves fixed modes and zero ranges, queues jobs.
// ----------------------------------------------------------------------------
module ublr_front
   import ublr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            mode,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RANGE_BITS-1:0] req_tdata,
   output logic                  job_valid,
   input  logic                  job_ready,
   output job_type               job
);

   // two-entry queue
   job_type     q_ff [2];
   job_type     q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic [RNG_BITS-1:0]  rng;
   job_type     nj;
   logic        push, pop;

   always_comb begin
      rng = (req_tdata > RANGE_BITS'(1 << CAND_BITS)) ? RNG_BITS'(1 << CAND_BITS)
                                                      : req_tdata[RNG_BITS-1:0];
      nj.range = rng;
      nj.draw  = 1'b0;
      nj.fixed = '0;
      if (rng != '0) begin
         case (mode)
            MODE_MIN:  nj.fixed = '0;
            MODE_HALF: nj.fixed = rng[CAND_BITS:1];
            MODE_MAX:  nj.fixed = CAND_BITS'(rng - RNG_BITS'(1));
            default:   nj.draw  = 1'b1;
         endcase
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign job_valid  = (cnt_ff != 2'd0);
   assign job        = q_ff[0];
   assign push       = req_tvalid && req_tready;
   assign pop        = job_valid && job_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) begin
            q_in[0] = nj;
         end else begin
            q_in[1] = nj;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_full_nopush: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count step");

endmodule

/* rtl/ublr_back.sv */
// ----------------------------------------------------------------------------
// ublr_back: generator and reduction engine
// Steps the 48-bit LCG with 16-bit partial products, rejects, then reduces
// the candidate mod range one quotient bit per cycle unless stalled.
// ----------------------------------------------------------------------------
module ublr_back
   import ublr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  seed_we,
   input  logic [STATE_BITS-1:0] seed,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  job_type               job,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CAND_BITS-1:0]  rsp_value
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LIM  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_MOD  = 3'd4;

   logic [2:0]            st_ff, st_in;
   logic [STATE_BITS-1:0] x_ff, x_in;
   logic [STATE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            pp_ff, pp_in;
   logic [RNG_BITS-1:0]   rng_ff, rng_in;
   logic [RNG_BITS-1:0]   rem_ff, rem_in;
   logic [CAND_BITS-1:0]  cand_ff, cand_in;
   logic [5:0]            bit_ff, bit_in;
   logic [CAND_BITS-1:0]  lim_ff, lim_in;
   logic                  lmode_ff, lmode_in;
   logic                  ov_ff, ov_in;
   logic [CAND_BITS-1:0]  out_ff, out_in;
   logic [15:0]           xs;
   logic [RNG_BITS:0]     trial;
   logic [51:0]           pprod;
   logic [STATE_BITS-1:0] prod;

   assign job_ready  = (st_ff == ST_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_value  = out_ff;
   assign xs         = x_ff[pp_ff*16 +: 16];
   // 16-bit slice times the 35-bit multiplier, full 51-bit product
   assign pprod      = {36'b0, xs} * {16'b0, LCG_MULT[35:0]};
   assign prod       = pprod[STATE_BITS-1:0] << (pp_ff * 16);
   // shift-subtract: operand is the candidate (lmode 0) or 2^31 (lmode 1)
   assign trial = {rem_ff, lmode_ff ? (bit_ff == 6'(CAND_BITS)) : cand_ff[bit_ff[4:0]]}
                  - {1'b0, rng_ff};

   always_comb begin
      st_in = st_ff; x_in = x_ff; acc_in = acc_ff; pp_in = pp_ff;
      rng_in = rng_ff; rem_in = rem_ff; cand_in = cand_ff; bit_in = bit_ff;
      lim_in = lim_ff; lmode_in = lmode_ff; ov_in = ov_ff; out_in = out_ff;
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (job_valid && !ov_ff) begin
               rng_in = job.range;
               if (job.draw) begin
                  rem_in = '0; bit_in = 6'(CAND_BITS); lmode_in = 1'b1;
                  st_in = ST_LIM;
               end else begin
                  out_in = job.fixed; ov_in = 1'b1;
               end
            end
         end
         ST_LIM: begin
            // 2^31 mod range, 32 bit steps
            rem_in = trial[RNG_BITS] ? RNG_BITS'({rem_ff, bit_ff == 6'(CAND_BITS)})
                                     : trial[RNG_BITS-1:0];
            if (bit_ff == '0) begin
               lim_in = CAND_BITS'({1'b0, {CAND_BITS{1'b1}}} - rem_in);
               acc_in = LCG_INC; pp_in = '0; st_in = ST_MUL;
            end else begin
               bit_in = bit_ff - 6'd1;
            end
         end
         ST_MUL: begin
            acc_in = acc_ff + prod;
            pp_in  = pp_ff + 2'd1;
            if (pp_ff == 2'd2) begin
               x_in = acc_in; st_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cand_in = x_ff[STATE_BITS-1 -: CAND_BITS];
            if (cand_in > lim_ff) begin
               acc_in = LCG_INC; pp_in = '0; st_in = ST_MUL;
            end else begin
               rem_in = '0; bit_in = 6'(CAND_BITS-1); lmode_in = 1'b0; st_in = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in = trial[RNG_BITS] ? RNG_BITS'({rem_ff, cand_ff[bit_ff[4:0]]})
                                     : trial[RNG_BITS-1:0];
            if (bit_ff == '0) begin
               if (!ov_in) begin
                  out_in = rem_in[CAND_BITS-1:0]; ov_in = 1'b1; st_in = ST_IDLE;
               end else begin
                  rem_in = rem_ff;
               end
            end else begin
               bit_in = bit_ff - 6'd1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (seed_we) begin
         x_in = seed;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; pp_ff <= pp_in; rng_ff <= rng_in; rem_ff <= rem_in;
      cand_ff <= cand_in; bit_ff <= bit_in; lim_ff <= lim_in; lmode_ff <= lmode_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0; x_ff <= SEED_RESET;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; x_ff <= x_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_value))
      else $error("result lost");
   a_noaccept: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !job_ready) else $error("accept while busy");
   a_less: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && $past(st_ff) == ST_MOD |-> {1'b0, rsp_value} < rng_ff)
      else $error("value not below range");

endmodule
